// ===== sv/tspc_pkg.sv =====
// Shared types, field widths and constants for the thick segment pixel coverage block.
package tspc_pkg;

	// Fixed point scale of the coordinates and thickness
	localparam int FRAC_BITS = 12;

	// Field widths
	localparam int COORD_W = 14;
	localparam int COL_W   = 8;
	localparam int ROW_W   = 9;
	localparam int W_W     = 8;
	localparam int T_W     = 13;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = T_W;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STROKE_THICKNESS = 1'b1;
	localparam logic [W_W-1:0] CELL_WIDTH_RST       = 8'd16;
	localparam logic [T_W-1:0] STROKE_THICKNESS_RST = 13'd512;

	// Datapath widths
	localparam int A_W    = COORD_W + 1;                      // signed coordinate difference
	localparam int XW_W   = COORD_W + W_W;                    // coordinate times cell width
	localparam int PX_W   = COL_W + FRAC_BITS;
	localparam int REL_W  = ROW_W + 1;                        // 2*W - row
	localparam int PY_W   = REL_W + FRAC_BITS;
	localparam int DM_W   = (XW_W > PY_W) ? XW_W : PY_W;
	localparam int D_W    = DM_W + 1;                         // signed offset to segment start
	localparam int P_W    = A_W + D_W;                        // signed partial product
	localparam int S_W    = P_W + 1;                          // signed dot products
	localparam int SQ_W   = 2 * COORD_W;                      // one squared difference
	localparam int N2_W   = SQ_W + 1;                         // squared length, raw units
	localparam int TW_W   = T_W + W_W;
	localparam int TW2_W  = 2 * TW_W;
	localparam int TL_W   = TW2_W / 2;
	localparam int TH_W   = TW2_W - TL_W;
	localparam int PL_W   = TL_W + N2_W;
	localparam int PH_W   = TH_W + N2_W;
	localparam int RHS_W  = TW2_W + N2_W;
	localparam int L2_W   = N2_W + W_W;
	localparam int MAG_W  = S_W;
	localparam int ML_W   = MAG_W / 2;
	localparam int MH_W   = MAG_W - ML_W;
	localparam int HH_W   = 2 * MH_W;
	localparam int HM_W   = MH_W + ML_W;
	localparam int LL_W   = 2 * ML_W;
	localparam int LHS_W  = 2 * MAG_W + 2;

	// Cycles from accepted command to result strobe
	localparam int LAT = 8;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COL_W-1:0]   pixel_col;
		logic [ROW_W-1:0]   pixel_row;
	} item_t;

	typedef struct packed {
		logic [W_W-1:0] cell_width;
		logic [T_W-1:0] stroke_thickness;
	} cfg_t;

	// Per stage control: item present, and no rule has ruled it out yet
	typedef struct packed {
		logic vld;
		logic ok;
	} ctl_t;

endpackage

// ===== sv/tspc_core.sv =====
// Eight stage datapath of the coverage test: scaling, products, squares and the final compare.
module tspc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  tspc_pkg::item_t item,
	input  tspc_pkg::cfg_t  cfg,
	output logic            out_vld,
	output logic            out_inked
);
	import tspc_pkg::*;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	logic signed [A_W-1:0]   a_s1, b_s1, a_s2, b_s2;
	logic [XW_W-1:0]         x1w_s1, y1w_s1;
	logic [TW_W-1:0]         tw_s1;
	logic [PX_W-1:0]         px_s1;
	logic [PY_W-1:0]         py_s1;
	logic signed [D_W-1:0]   dx_s2, dy_s2;
	logic [N2_W-1:0]         n2_s2, n2_s3;
	logic [TW2_W-1:0]        tw2_s2, tw2_s3;
	logic signed [P_W-1:0]   p_adx_s3, p_bdy_s3, p_ady_s3, p_bdx_s3;
	logic signed [S_W-1:0]   dist_s4, dot_s4;
	logic [L2_W-1:0]         len2_s4;
	logic [PH_W-1:0]         ph_s4;
	logic [PL_W-1:0]         pl_s4;
	logic [MAG_W-1:0]        mag_s5;
	logic [RHS_W-1:0]        rhs_s5, rhs_s6, rhs_s7;
	logic [HH_W-1:0]         hh_s6;
	logic [HM_W-1:0]         hm_s6;
	logic [LL_W-1:0]         ll_s6;
	logic [LHS_W-1:0]        lhs_s7;
	logic                    inked_s8;

	logic signed [A_W-1:0]   a_c, b_c;
	logic [REL_W-1:0]        rel_c;
	logic                    ok_c;
	logic signed [S_W-1:0]   dist_neg_c;
	logic                    foot_c;
	logic [MH_W-1:0]         mh_c;
	logic [ML_W-1:0]         ml_c;
	logic signed [2*A_W-1:0] aa_c, bb_c;

	// Stage 1 inputs: line normal, row offset from the cell bottom, pixel and segment checks
	always_comb begin
		a_c   = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
		b_c   = $signed({1'b0, item.start_x}) - $signed({1'b0, item.end_x});
		rel_c = {1'b0, cfg.cell_width, 1'b0} - {1'b0, item.pixel_row};
		ok_c  = (item.pixel_col < cfg.cell_width)
			&& (item.pixel_row < {cfg.cell_width, 1'b0})
			&& !((item.start_x == item.end_x) && (item.start_y == item.end_y));
	end

	// Stage 2 squares of the normal components
	always_comb begin
		aa_c = a_s1 * a_s1;
		bb_c = b_s1 * b_s1;
	end

	// Stage 5 inputs: magnitude of the distance term, foot of perpendicular inside the segment
	always_comb begin
		dist_neg_c = -dist_s4;
		foot_c = !dot_s4[S_W-1] && (dot_s4[S_W-2:0] <= (S_W-1)'(len2_s4));
	end

	// Stage 6 inputs: split the magnitude for the squaring
	always_comb begin
		mh_c = mag_s5[MAG_W-1:ML_W];
		ml_c = mag_s5[ML_W-1:0];
	end

	// Advance the control bits every cycle; the receiver never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s1 <= '{vld: in_vld, ok: ok_c};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= '{vld: ctl_s4.vld, ok: ctl_s4.ok && foot_c};
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// s1: scale the segment start and the thickness by the cell width
		a_s1   <= a_c;
		b_s1   <= b_c;
		x1w_s1 <= XW_W'(item.start_x) * XW_W'(cfg.cell_width);
		y1w_s1 <= XW_W'(item.start_y) * XW_W'(cfg.cell_width);
		tw_s1  <= TW_W'(cfg.stroke_thickness) * TW_W'(cfg.cell_width);
		px_s1  <= {item.pixel_col, {FRAC_BITS{1'b0}}};
		py_s1  <= {rel_c, {FRAC_BITS{1'b0}}};

		// s2: offsets of the pixel from the start, squared length, squared thickness
		dx_s2  <= $signed({{(D_W-PX_W){1'b0}}, px_s1}) - $signed({{(D_W-XW_W){1'b0}}, x1w_s1});
		dy_s2  <= $signed({{(D_W-PY_W){1'b0}}, py_s1}) - $signed({{(D_W-XW_W){1'b0}}, y1w_s1});
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		n2_s2  <= N2_W'(aa_c[SQ_W-1:0]) + N2_W'(bb_c[SQ_W-1:0]);
		tw2_s2 <= TW2_W'(tw_s1) * TW2_W'(tw_s1);

		// s3: the four cross products
		p_adx_s3 <= P_W'(a_s2) * P_W'(dx_s2);
		p_bdy_s3 <= P_W'(b_s2) * P_W'(dy_s2);
		p_ady_s3 <= P_W'(a_s2) * P_W'(dy_s2);
		p_bdx_s3 <= P_W'(b_s2) * P_W'(dx_s2);
		n2_s3    <= n2_s2;
		tw2_s3   <= tw2_s2;

		// s4: distance and projection sums, segment length bound, thickness bound halves
		dist_s4 <= S_W'(p_adx_s3) + S_W'(p_bdy_s3);
		dot_s4  <= S_W'(p_ady_s3) - S_W'(p_bdx_s3);
		len2_s4 <= L2_W'(n2_s3) * L2_W'(cfg.cell_width);
		ph_s4   <= PH_W'(tw2_s3[TW2_W-1:TL_W]) * PH_W'(n2_s3);
		pl_s4   <= PL_W'(tw2_s3[TL_W-1:0]) * PL_W'(n2_s3);

		// s5: magnitude and the full thickness bound
		mag_s5 <= dist_s4[S_W-1] ? $unsigned(dist_neg_c) : $unsigned(dist_s4);
		rhs_s5 <= (RHS_W'(ph_s4) << TL_W) + RHS_W'(pl_s4);

		// s6: partial squares of the magnitude
		hh_s6  <= HH_W'(mh_c) * HH_W'(mh_c);
		hm_s6  <= HM_W'(mh_c) * HM_W'(ml_c);
		ll_s6  <= LL_W'(ml_c) * LL_W'(ml_c);
		rhs_s6 <= rhs_s5;

		// s7: four times the squared distance term
		lhs_s7 <= (LHS_W'(hh_s6) << (2 * ML_W + 2)) + (LHS_W'(hm_s6) << (ML_W + 3))
			+ (LHS_W'(ll_s6) << 2);
		rhs_s7 <= rhs_s6;

		// s8: final decision
		inked_s8 <= ctl_s7.ok && (lhs_s7 <= LHS_W'(rhs_s7));
	end

	assign out_vld   = ctl_s8.vld;
	assign out_inked = ctl_s8.vld && inked_s8;

endmodule

// ===== sv/thick_segment_pixel_coverage.sv =====
// Top level of the thick segment pixel coverage test: configuration registers and command port.
//
// Each command asks whether one pixel of a glyph cell (cell_width wide, twice as high) lies on
// a thick segment given in Q2.12 cell widths. A command is taken in every clock cycle in which
// start is high; busy is always low. Its answer appears on inked, with done high for one cycle,
// once the command has passed the eight register stages of the datapath
// (multipliers up to 21 by 29 bits, with the 39 bit distance term squared in three pieces).
// Answers come out in command order and cannot be held off. Write cell_width and
// stroke_thickness only while no command is in flight.
module thick_segment_pixel_coverage (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tspc_pkg::COORD_W-1:0]         start_x,
	input  logic [tspc_pkg::COORD_W-1:0]         start_y,
	input  logic [tspc_pkg::COORD_W-1:0]         end_x,
	input  logic [tspc_pkg::COORD_W-1:0]         end_y,
	input  logic [tspc_pkg::COL_W-1:0]           pixel_col,
	input  logic [tspc_pkg::ROW_W-1:0]           pixel_row,
	output logic                                 done,
	output logic                                 inked,
	input  logic                                 cfg_we,
	input  logic [tspc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tspc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tspc_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	logic  accept;

	// The pipeline takes a command every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign item = '{start_x: start_x, start_y: start_y, end_x: end_x, end_y: end_y,
		pixel_col: pixel_col, pixel_row: pixel_row};

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_width       <= CELL_WIDTH_RST;
			cfg_q.stroke_thickness <= STROKE_THICKNESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELL_WIDTH: begin
					cfg_q.cell_width <= cfg_data[W_W-1:0];
				end
				CFG_STROKE_THICKNESS: begin
					cfg_q.stroke_thickness <= cfg_data[T_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tspc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (accept),
		.item     (item),
		.cfg      (cfg_q),
		.out_vld  (done),
		.out_inked(inked)
	);

`ifndef SYNTH
	// Every answer belongs to a transfer a fixed latency earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("done without a matching command");

	// A zero-length segment never inks
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && inked |-> $past((start_x != end_x) || (start_y != end_y), LAT))
		else $error("zero-length segment inked a pixel");

	// A pixel outside the cell never inks
	a_in_cell: assert property (@(posedge clk) disable iff (!arst_n)
		done && inked |-> $past((pixel_col < cfg_q.cell_width)
			&& (pixel_row < {cfg_q.cell_width, 1'b0}), LAT))
		else $error("pixel outside the cell inked");
`endif

endmodule

// ===== bench/thick_segment_pixel_coverage_tb.sv =====
// Self-checking testbench for the thick segment pixel coverage block.
`timescale 1ns / 100ps

module thick_segment_pixel_coverage_tb;

	import tspc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_EVERY = 97;

	typedef struct {
		item_t cmd;
		bit    inked;
	} pixel_check_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	item_t cmd_drv = '0;
	logic done;
	logic inked;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CELL_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Pending commands, expected answers and the shadow of the registers
	item_t segment_cmds[$];
	pixel_check_t inked_expected[$];
	pixel_check_t head;
	logic [W_W-1:0] cell_width_cfg = CELL_WIDTH_RST;
	logic [T_W-1:0] thickness_cfg = STROKE_THICKNESS_RST;
	int idle_pct = 36;
	int transfers = 0;
	bit draining = 1'b0;
	int errors = 0;
	int cycle_cnt = 0;

	thick_segment_pixel_coverage u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.start_x   (cmd_drv.start_x),
		.start_y   (cmd_drv.start_y),
		.end_x     (cmd_drv.end_x),
		.end_y     (cmd_drv.end_y),
		.pixel_col (cmd_drv.pixel_col),
		.pixel_row (cmd_drv.pixel_row),
		.done      (done),
		.inked     (inked),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Exact coverage test, all points scaled by 2^FRAC_BITS * cell width
	function automatic bit pixel_inked(item_t c, logic [W_W-1:0] w8, logic [T_W-1:0] t13);
		longint x1, y1, x2, y2, col, row, w, t, a, b, dx, dy, dist_sum, dot, len2;
		logic signed [127:0] lhs, rhs;
		x1 = longint'(c.start_x);
		y1 = longint'(c.start_y);
		x2 = longint'(c.end_x);
		y2 = longint'(c.end_y);
		col = longint'(c.pixel_col);
		row = longint'(c.pixel_row);
		w = longint'(w8);
		t = longint'(t13);
		// pixel outside the cell, including an empty cell
		if (col >= w || row >= 2 * w)
			return 1'b0;
		a = y2 - y1;
		b = x1 - x2;
		// zero-length segment has no line
		if (a == 0 && b == 0)
			return 1'b0;
		dx = (col << FRAC_BITS) - x1 * w;
		dy = ((2 * w - row) << FRAC_BITS) - y1 * w;
		dist_sum = a * dx + b * dy;
		lhs = dist_sum;
		lhs = lhs * lhs * 4;
		rhs = t * w;
		rhs = rhs * rhs * (a * a + b * b);
		if (lhs > rhs)
			return 1'b0;
		// foot of the perpendicular must fall on the segment
		dot = dx * (x2 - x1) + dy * (y2 - y1);
		len2 = (a * a + b * b) * w;
		return dot >= 0 && dot <= len2;
	endfunction

	function automatic item_t random_cmd(int w);
		item_t c;
		int kind, x1, y1, x2, y2, u, px, py, col, row;
		kind = $urandom_range(99);
		if (kind < 10) begin
			// raw fields over their whole width
			c.start_x = COORD_W'($urandom);
			c.start_y = COORD_W'($urandom);
			c.end_x = COORD_W'($urandom);
			c.end_y = COORD_W'($urandom);
			c.pixel_col = COL_W'($urandom);
			c.pixel_row = ROW_W'($urandom);
			return c;
		end
		x1 = $urandom_range(4096);
		y1 = $urandom_range(8192);
		x2 = $urandom_range(4096);
		y2 = $urandom_range(8192);
		if (kind < 15) begin
			x2 = x1;
			y2 = y1;
		end else if (kind < 20) begin
			y2 = y1;
		end else if (kind < 25) begin
			x2 = x1;
		end
		c.start_x = COORD_W'(x1);
		c.start_y = COORD_W'(y1);
		c.end_x = COORD_W'(x2);
		c.end_y = COORD_W'(y2);
		if (w == 0) begin
			c.pixel_col = COL_W'($urandom);
			c.pixel_row = ROW_W'($urandom);
		end else if ($urandom_range(99) < 20) begin
			c.pixel_col = COL_W'($urandom_range(w - 1));
			c.pixel_row = ROW_W'($urandom_range(2 * w - 1));
		end else begin
			// land near the segment, a little past its ends at times
			u = int'($urandom_range(288)) - 16;
			px = x1 + (x2 - x1) * u / 256;
			py = y1 + (y2 - y1) * u / 256;
			col = px * w / 4096 + int'($urandom_range(2)) - 1;
			row = (8192 - py) * w / 4096 + int'($urandom_range(2)) - 1;
			col = col < 0 ? 0 : (col > 255 ? 255 : col);
			row = row < 0 ? 0 : (row > 511 ? 511 : row);
			c.pixel_col = COL_W'(col);
			c.pixel_row = ROW_W'(row);
		end
		return c;
	endfunction

	task automatic push_cmd(int x1, int y1, int x2, int y2, int col, int row);
		item_t c;
		c.start_x = COORD_W'(x1);
		c.start_y = COORD_W'(y1);
		c.end_x = COORD_W'(x2);
		c.end_y = COORD_W'(y2);
		c.pixel_col = COL_W'(col);
		c.pixel_row = ROW_W'(row);
		segment_cmds.push_back(c);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (segment_cmds.size() != 0 || inked_expected.size() != 0 || start);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Reconfigure while idle, then queue a batch of random commands
	task automatic run_phase(int w, int t, int n, int pct);
		logic [CFG_DATA_W-1:0] wdata;
		wait_drained();
		wdata = CFG_DATA_W'($urandom);
		wdata[W_W-1:0] = W_W'(w);
		write_reg(CFG_CELL_WIDTH, wdata);
		cell_width_cfg = W_W'(w);
		write_reg(CFG_STROKE_THICKNESS, CFG_DATA_W'(t));
		thickness_cfg = T_W'(t);
		@(negedge clk);
		idle_pct = pct;
		repeat (n) segment_cmds.push_back(random_cmd(w));
	endtask

	// Present commands and log each transfer with its expected answer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd_drv <= '0;
		end else begin
			if (start && !busy) begin
				inked_expected.push_back('{cmd: cmd_drv,
					inked: pixel_inked(cmd_drv, cell_width_cfg, thickness_cfg)});
				void'(segment_cmds.pop_front());
				transfers++;
				if (transfers % DRAIN_EVERY == 0)
					draining = 1'b1;
			end
			if (draining && inked_expected.size() == 0)
				draining = 1'b0;
			// hold a refused command, else offer the next one or idle
			if (!(start && busy)) begin
				if (!draining && segment_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					cmd_drv <= segment_cmds[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Check each answer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (inked_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected answer, expected none, actual inked=%b", $time, inked);
			end else begin
				head = inked_expected.pop_front();
				if (inked !== head.inked) begin
					errors++;
					$display("%0t: inked mismatch, expected %b, actual %b (%0d,%0d)-(%0d,%0d) px %0d,%0d",
						$time, head.inked, inked, head.cmd.start_x, head.cmd.start_y,
						head.cmd.end_x, head.cmd.end_y, head.cmd.pixel_col, head.cmd.pixel_row);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_pct = 36;

		// directed commands under the reset configuration
		push_cmd(2048, 4096, 2048, 4096, 8, 16);       // zero-length on the pixel
		push_cmd(0, 0, 0, 0, 0, 31);                    // zero-length at the origin
		push_cmd(0, 4096, 4096, 4096, 8, 16);           // horizontal through pixel
		push_cmd(4096, 4096, 0, 4096, 8, 16);           // same, reversed
		push_cmd(2048, 0, 2048, 8192, 8, 10);           // vertical through pixel
		push_cmd(0, 4096, 4096, 4096, 8, 15);           // distance exactly half thickness
		push_cmd(0, 4096, 4096, 4096, 8, 14);           // just past the stroke
		push_cmd(0, 4096, 2048, 4096, 8, 16);           // foot on the end point
		push_cmd(0, 4096, 2048, 4096, 9, 16);           // foot past the end point
		push_cmd(0, 4096, 1024, 4096, 8, 16);           // foot well outside
		push_cmd(0, 4096, 4096, 4096, 16, 16);          // column at cell width
		push_cmd(0, 4096, 4096, 4096, 255, 16);         // column at maximum
		push_cmd(0, 4096, 4096, 4096, 8, 32);           // row at twice cell width
		push_cmd(0, 4096, 4096, 4096, 8, 511);          // row at maximum
		push_cmd(0, 0, 4096, 8192, 8, 16);              // diagonal through pixel
		push_cmd(4096, 8192, 0, 0, 15, 1);              // diagonal, far corner
		push_cmd(0, 0, 8192, 8192, 0, 0);               // top left pixel
		push_cmd(8192, 8192, 0, 8192, 0, 0);            // top edge
		push_cmd(16383, 16383, 0, 0, 15, 31);           // coordinates at field maximum
		push_cmd(16383, 0, 0, 16383, 0, 31);
		push_cmd(8192, 0, 0, 0, 15, 31);                // bottom edge
		repeat (150) segment_cmds.push_back(random_cmd(int'(cell_width_cfg)));

		run_phase(255, 4096, 60, 36);
		run_phase(1, 0, 40, 36);
		run_phase(8, 8191, 60, 36);
		run_phase(0, 1024, 20, 36);
		run_phase(24, 700, 150, 0);
		run_phase($urandom_range(1, 64), $urandom_range(4096), 170, 36);

		wait_drained();
		repeat (LAT + 4) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
